FILE: hdl/gpio_pkg.sv
`default_nettype none

package gpio_pkg;

    typedef enum logic [1:0] {
        CMD_READ   = 2'd0,
        CMD_WRITE  = 2'd1,
        CMD_SAMPLE = 2'd2
    } cmd_t;

    typedef enum logic [3:0] {
        REG_MODE     = 4'd0,
        REG_OTYPE    = 4'd1,
        REG_SPEED    = 4'd2,
        REG_PULL     = 4'd3,
        REG_INPUT    = 4'd4,
        REG_OUTPUT   = 4'd5,
        REG_SETRESET = 4'd6,
        REG_AFL      = 4'd7,
        REG_AFH      = 4'd8,
        REG_MASK     = 4'd9,
        REG_RISE     = 4'd10,
        REG_FALL     = 4'd11,
        REG_PENDING  = 4'd12
    } reg_idx_t;

    localparam int unsigned MAX_PINS = 16;
    localparam logic [1:0] MODE_OUTPUT = 2'b01;

    typedef struct packed {
        logic [1:0]  command;
        logic [3:0]  reg_index;
        logic [31:0] write_data;
        logic [15:0] pin_levels;
    } req_beat_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic [15:0] pin_out;
        logic [15:0] pin_drive_enable;
        logic        irq;
    } rsp_beat_t;

endpackage

`default_nettype wire

FILE: hdl/gpio_req_if.sv
`default_nettype none

interface gpio_req_if
    import gpio_pkg::*;
();
    logic      valid;
    logic      ready;
    req_beat_t beat;

    modport source (output valid, output beat, input ready);
    modport sink (input valid, input beat, output ready);
endinterface

`default_nettype wire

FILE: hdl/gpio_rsp_if.sv
`default_nettype none

interface gpio_rsp_if
    import gpio_pkg::*;
();
    logic      valid;
    logic      ready;
    rsp_beat_t beat;

    modport source (output valid, output beat, input ready);
    modport sink (input valid, input beat, output ready);
endinterface

`default_nettype wire

FILE: hdl/gpio_port_with_edge_interrupts.sv
`default_nettype none

// General-purpose I/O port of up to 16 pins with edge interrupts. Each request beat is a
// bus read, a bus write or a pin sample and yields exactly one response beat carrying the
// read data (zero unless a read), the output data driven to the pads, the drive enables
// (pins whose mode field is 01) and the interrupt request, all as they stand after the beat
// is applied. The set/reset word sets output bits with its low half and clears them with
// its high half, set winning; pending bits clear on a write of 1. Register updates are
// plain logic in front of the state flops, so one beat is taken every cycle while the
// response buffer has room, and its response is registered into the buffer; a two-entry
// response buffer keeps the request side open for one extra beat while the response side
// stalls. Bits of pins at or above PIN_COUNT stay zero.
module gpio_port_with_edge_interrupts
    import gpio_pkg::*;
#(
    parameter int unsigned PIN_COUNT = 16
) (
    input  wire        clk,
    input  wire        rst_n,
    gpio_req_if.sink   req,
    gpio_rsp_if.source rsp
);

    localparam int unsigned AF_LO_PINS = (PIN_COUNT > 8) ? 8 : PIN_COUNT;
    localparam int unsigned AF_HI_PINS = (PIN_COUNT > 8) ? PIN_COUNT - 8 : 0;
    localparam logic [15:0] PIN_MASK   = 16'((64'h1 << PIN_COUNT) - 64'h1);
    localparam logic [31:0] PAIR_MASK  = 32'((64'h1 << (2 * PIN_COUNT)) - 64'h1);
    localparam logic [31:0] AFL_MASK   = 32'((64'h1 << (4 * AF_LO_PINS)) - 64'h1);
    localparam logic [31:0] AFH_MASK   = 32'((64'h1 << (4 * AF_HI_PINS)) - 64'h1);

    logic [31:0] mode_reg, mode_next;
    logic [15:0] otype_reg, otype_next;
    logic [31:0] speed_reg, speed_next;
    logic [31:0] pull_reg, pull_next;
    logic [31:0] afl_reg, afl_next;
    logic [31:0] afh_reg, afh_next;
    logic [15:0] input_reg, input_next;
    logic [15:0] output_reg, output_next;
    logic [15:0] mask_reg, mask_next;
    logic [15:0] rise_reg, rise_next;
    logic [15:0] fall_reg, fall_next;
    logic [15:0] pend_reg, pend_next;

    logic      out_valid_reg, out_valid_next;
    logic      skid_valid_reg, skid_valid_next;
    rsp_beat_t out_reg, out_next;
    rsp_beat_t skid_reg, skid_next;

    logic      req_fire;
    logic      rsp_take;
    rsp_beat_t result;
    logic [31:0] rd_data;
    logic [15:0] set_bits;
    logic [15:0] clr_bits;
    logic [15:0] now_levels;
    logic [15:0] drive_en;

    assign req.ready = !skid_valid_reg;
    assign req_fire  = req.valid && req.ready;
    assign rsp_take  = rsp.valid && rsp.ready;
    assign rsp.valid = out_valid_reg;
    assign rsp.beat  = out_reg;

    assign set_bits   = req.beat.write_data[15:0] & PIN_MASK;
    assign clr_bits   = req.beat.write_data[31:16] & PIN_MASK;
    assign now_levels = req.beat.pin_levels & PIN_MASK;

    always_comb
    begin
        mode_next   = mode_reg;
        otype_next  = otype_reg;
        speed_next  = speed_reg;
        pull_next   = pull_reg;
        afl_next    = afl_reg;
        afh_next    = afh_reg;
        input_next  = input_reg;
        output_next = output_reg;
        mask_next   = mask_reg;
        rise_next   = rise_reg;
        fall_next   = fall_reg;
        pend_next   = pend_reg;
        rd_data     = 32'h0;

        if (req_fire)
        begin
            unique case (req.beat.command)
                CMD_READ:
                begin
                    unique case (req.beat.reg_index)
                        REG_MODE:    rd_data = mode_reg;
                        REG_OTYPE:   rd_data = {16'h0, otype_reg};
                        REG_SPEED:   rd_data = speed_reg;
                        REG_PULL:    rd_data = pull_reg;
                        REG_INPUT:   rd_data = {16'h0, input_reg};
                        REG_OUTPUT:  rd_data = {16'h0, output_reg};
                        REG_AFL:     rd_data = afl_reg;
                        REG_AFH:     rd_data = afh_reg;
                        REG_MASK:    rd_data = {16'h0, mask_reg};
                        REG_RISE:    rd_data = {16'h0, rise_reg};
                        REG_FALL:    rd_data = {16'h0, fall_reg};
                        REG_PENDING: rd_data = {16'h0, pend_reg};
                        default:     rd_data = 32'h0;
                    endcase
                end
                CMD_WRITE:
                begin
                    unique case (req.beat.reg_index)
                        REG_MODE:     mode_next   = req.beat.write_data & PAIR_MASK;
                        REG_OTYPE:    otype_next  = req.beat.write_data[15:0] & PIN_MASK;
                        REG_SPEED:    speed_next  = req.beat.write_data & PAIR_MASK;
                        REG_PULL:     pull_next   = req.beat.write_data & PAIR_MASK;
                        REG_OUTPUT:   output_next = req.beat.write_data[15:0] & PIN_MASK;
                        // set wins over reset on the same pin
                        REG_SETRESET: output_next = (output_reg & ~clr_bits) | set_bits;
                        REG_AFL:      afl_next    = req.beat.write_data & AFL_MASK;
                        REG_AFH:      afh_next    = req.beat.write_data & AFH_MASK;
                        REG_MASK:     mask_next   = req.beat.write_data[15:0] & PIN_MASK;
                        REG_RISE:     rise_next   = req.beat.write_data[15:0] & PIN_MASK;
                        REG_FALL:     fall_next   = req.beat.write_data[15:0] & PIN_MASK;
                        REG_PENDING:  pend_next   = pend_reg & ~(req.beat.write_data[15:0]);
                        default:      ;
                    endcase
                end
                CMD_SAMPLE:
                begin
                    pend_next  = pend_reg
                               | (~input_reg & now_levels & rise_reg)
                               | (input_reg & ~now_levels & fall_reg);
                    input_next = now_levels;
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        drive_en = 16'h0;
        for (int i = 0; i < MAX_PINS; i++)
        begin
            drive_en[i] = (mode_next[2*i +: 2] == MODE_OUTPUT);
        end
    end

    always_comb
    begin
        result.read_data        = rd_data;
        result.pin_out          = output_next;
        result.pin_drive_enable = drive_en;
        result.irq              = |(pend_next & mask_next);
    end

    // two-entry response buffer
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;

        if (rsp_take)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                skid_valid_next = req_fire;
                skid_next       = result;
            end
            else
            begin
                out_valid_next = req_fire;
                out_next       = result;
            end
        end
        else if (!out_valid_reg)
        begin
            out_valid_next = req_fire;
            out_next       = result;
        end
        else if (req_fire)
        begin
            skid_valid_next = 1'b1;
            skid_next       = result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= 32'h0;
            otype_reg      <= 16'h0;
            speed_reg      <= 32'h0;
            pull_reg       <= 32'h0;
            afl_reg        <= 32'h0;
            afh_reg        <= 32'h0;
            input_reg      <= 16'h0;
            output_reg     <= 16'h0;
            mask_reg       <= 16'h0;
            rise_reg       <= 16'h0;
            fall_reg       <= 16'h0;
            pend_reg       <= 16'h0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg       <= mode_next;
            otype_reg      <= otype_next;
            speed_reg      <= speed_next;
            pull_reg       <= pull_next;
            afl_reg        <= afl_next;
            afh_reg        <= afh_next;
            input_reg      <= input_next;
            output_reg     <= output_next;
            mask_reg       <= mask_next;
            rise_reg       <= rise_next;
            fall_reg       <= fall_next;
            pend_reg       <= pend_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

endmodule

`default_nettype wire

FILE: bench/gpio_port_checker.sv
module gpio_port_checker
    import gpio_pkg::*;
#(
    parameter int unsigned PIN_COUNT = 16
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         req_valid,
    input  wire         req_ready,
    input  req_beat_t   req_beat,
    input  wire         rsp_valid,
    input  wire         rsp_ready,
    input  rsp_beat_t   rsp_beat,
    output int unsigned fail_count,
    output int unsigned outstanding
);

    // bits that exist for the configured pin count
    localparam logic [31:0] PIN_MSK  = 32'((64'd1 << PIN_COUNT) - 64'd1);
    localparam logic [31:0] PAIR_MSK = 32'((64'd1 << (2 * PIN_COUNT)) - 64'd1);
    localparam int unsigned AFL_PINS = (PIN_COUNT > 8) ? 8 : PIN_COUNT;
    localparam int unsigned AFH_PINS = (PIN_COUNT > 8) ? PIN_COUNT - 8 : 0;
    localparam logic [31:0] AFL_MSK  = 32'((64'd1 << (4 * AFL_PINS)) - 64'd1);
    localparam logic [31:0] AFH_MSK  = 32'((64'd1 << (4 * AFH_PINS)) - 64'd1);

    logic [31:0] mode_q;
    logic [15:0] otype_q;
    logic [31:0] speed_q;
    logic [31:0] pull_q;
    logic [31:0] afl_q;
    logic [31:0] afh_q;
    logic [15:0] in_q;
    logic [15:0] out_q;
    logic [15:0] mask_q;
    logic [15:0] rise_q;
    logic [15:0] fall_q;
    logic [15:0] pend_q;

    rsp_beat_t   port_status_q[$];
    int unsigned mismatches = 0;

    assign fail_count = mismatches;

    // applies one request beat to the port state and returns the response it yields
    function automatic rsp_beat_t apply_port_beat(req_beat_t b);
        rsp_beat_t   r;
        logic [15:0] pm;
        logic [15:0] now;
        logic [15:0] rose;
        logic [15:0] fell;
        r  = '0;
        pm = PIN_MSK[15:0];
        case (b.command)
            CMD_READ:
            begin
                case (b.reg_index)
                    REG_MODE:    r.read_data = mode_q;
                    REG_OTYPE:   r.read_data = {16'd0, otype_q};
                    REG_SPEED:   r.read_data = speed_q;
                    REG_PULL:    r.read_data = pull_q;
                    REG_INPUT:   r.read_data = {16'd0, in_q};
                    REG_OUTPUT:  r.read_data = {16'd0, out_q};
                    REG_AFL:     r.read_data = afl_q;
                    REG_AFH:     r.read_data = afh_q;
                    REG_MASK:    r.read_data = {16'd0, mask_q};
                    REG_RISE:    r.read_data = {16'd0, rise_q};
                    REG_FALL:    r.read_data = {16'd0, fall_q};
                    REG_PENDING: r.read_data = {16'd0, pend_q};
                    default:     r.read_data = '0;
                endcase
            end
            CMD_WRITE:
            begin
                case (b.reg_index)
                    REG_MODE:     mode_q  = b.write_data & PAIR_MSK;
                    REG_OTYPE:    otype_q = b.write_data[15:0] & pm;
                    REG_SPEED:    speed_q = b.write_data & PAIR_MSK;
                    REG_PULL:     pull_q  = b.write_data & PAIR_MSK;
                    REG_OUTPUT:   out_q   = b.write_data[15:0] & pm;
                    // set half wins over reset half
                    REG_SETRESET: out_q   = ((out_q & ~(b.write_data[31:16] & pm))
                                            | (b.write_data[15:0] & pm)) & pm;
                    REG_AFL:      afl_q   = b.write_data & AFL_MSK;
                    REG_AFH:      afh_q   = b.write_data & AFH_MSK;
                    REG_MASK:     mask_q  = b.write_data[15:0] & pm;
                    REG_RISE:     rise_q  = b.write_data[15:0] & pm;
                    REG_FALL:     fall_q  = b.write_data[15:0] & pm;
                    REG_PENDING:  pend_q  = pend_q & ~(b.write_data[15:0] & pm);
                    default:      ;
                endcase
            end
            CMD_SAMPLE:
            begin
                now    = b.pin_levels & pm;
                rose   = ~in_q & now & rise_q;
                fell   = in_q & ~now & fall_q;
                pend_q = (pend_q | rose | fell) & pm;
                in_q   = now;
            end
            default: ;
        endcase
        r.pin_out = out_q;
        for (int i = 0; i < PIN_COUNT; i++)
        begin
            r.pin_drive_enable[i] = (mode_q[2 * i +: 2] == MODE_OUTPUT);
        end
        r.irq = |(pend_q & mask_q);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rsp_beat_t want;
        if (!rst_n)
        begin
            mode_q  = '0;
            otype_q = '0;
            speed_q = '0;
            pull_q  = '0;
            afl_q   = '0;
            afh_q   = '0;
            in_q    = '0;
            out_q   = '0;
            mask_q  = '0;
            rise_q  = '0;
            fall_q  = '0;
            pend_q  = '0;
            port_status_q.delete();
            outstanding <= 0;
        end
        else
        begin
            // a response never belongs to a request taken on the same edge
            if (rsp_valid && rsp_ready)
            begin
                if (port_status_q.size() == 0)
                begin
                    $error("response beat with no request waiting");
                    mismatches++;
                end
                else
                begin
                    want = port_status_q.pop_front();
                    if (rsp_beat.read_data !== want.read_data)
                    begin
                        $error("read_data: expected %h, got %h",
                               want.read_data, rsp_beat.read_data);
                        mismatches++;
                    end
                    if (rsp_beat.pin_out !== want.pin_out)
                    begin
                        $error("pin_out: expected %h, got %h", want.pin_out, rsp_beat.pin_out);
                        mismatches++;
                    end
                    if (rsp_beat.pin_drive_enable !== want.pin_drive_enable)
                    begin
                        $error("pin_drive_enable: expected %h, got %h",
                               want.pin_drive_enable, rsp_beat.pin_drive_enable);
                        mismatches++;
                    end
                    if (rsp_beat.irq !== want.irq)
                    begin
                        $error("irq: expected %b, got %b", want.irq, rsp_beat.irq);
                        mismatches++;
                    end
                end
            end
            if (req_valid && req_ready)
            begin
                port_status_q.push_back(apply_port_beat(req_beat));
            end
            outstanding <= port_status_q.size();
        end
    end

endmodule

FILE: bench/gpio_port_with_edge_interrupts_tb.sv
module gpio_port_with_edge_interrupts_tb;
    import gpio_pkg::*;

    localparam int unsigned PIN_COUNT    = 16;
    localparam int unsigned RANDOM_BEATS = 450;
    localparam logic [1:0]  CMD_UNUSED   = 2'd3;
    localparam logic [3:0]  REG_UNUSED_LO = 4'd13;
    localparam logic [3:0]  REG_UNUSED_HI = 4'd15;

    logic        clk;
    logic        rst_n;
    int unsigned fail_count;
    int unsigned outstanding;
    bit          idle_on = 1'b1;
    int unsigned stall_left;
    logic [15:0] last_levels = '0;

    gpio_req_if req_ch ();
    gpio_rsp_if rsp_ch ();

    gpio_port_with_edge_interrupts #(
        .PIN_COUNT (PIN_COUNT)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    gpio_port_checker #(
        .PIN_COUNT (PIN_COUNT)
    ) port_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_ch.valid),
        .req_ready   (req_ch.ready),
        .req_beat    (req_ch.beat),
        .rsp_valid   (rsp_ch.valid),
        .rsp_ready   (rsp_ch.ready),
        .rsp_beat    (rsp_ch.beat),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

    // response side back-pressure: mostly short stalls, now and then a long one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            stall_left = 0;
        end
        else if (stall_left != 0)
        begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            rsp_ch.ready <= 1'b1;
            if (idle_on && $urandom_range(0, 3) == 0)
            begin
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
                                                         : $urandom_range(1, 3);
            end
        end
    end

    // optional idle gap, then hold the beat until it is taken
    task automatic send_beat(input logic [1:0] cmd, input logic [3:0] idx,
                             input logic [31:0] data, input logic [15:0] levels);
        int unsigned gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 1) == 0)
        begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 3);
        end
        if (gap != 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.beat  <= '{command: cmd, reg_index: idx, write_data: data, pin_levels: levels};
        do
            @(posedge clk);
        while (!req_ch.ready);
    endtask

    // stop sending until every response is back
    task automatic drain_responses();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    initial
    begin
        int unsigned roll;
        int unsigned pick;
        logic [3:0]  idx;
        logic [31:0] data;
        logic [15:0] levels;

        rst_n        <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.beat  <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every pin to output, then all-ones into each config register
        send_beat(CMD_WRITE, REG_MODE, 32'h5555_5555, '0);
        send_beat(CMD_WRITE, REG_OTYPE, 32'hFFFF_FFFF, '0);
        send_beat(CMD_WRITE, REG_SPEED, 32'hFFFF_FFFF, '0);
        send_beat(CMD_WRITE, REG_PULL, 32'hFFFF_FFFF, '0);
        send_beat(CMD_WRITE, REG_AFL, 32'hFFFF_FFFF, '0);
        send_beat(CMD_WRITE, REG_AFH, 32'hFFFF_FFFF, '0);
        // input data is read-only
        send_beat(CMD_WRITE, REG_INPUT, 32'hFFFF_FFFF, '0);
        send_beat(CMD_READ, REG_INPUT, '0, '0);
        send_beat(CMD_WRITE, REG_OUTPUT, 32'hFFFF_FFFF, '0);
        send_beat(CMD_WRITE, REG_SETRESET, 32'hFFFF_0000, '0);
        // set and reset on the same bits: set wins
        send_beat(CMD_WRITE, REG_SETRESET, 32'hFFFF_FFFF, '0);
        send_beat(CMD_READ, REG_SETRESET, '0, '0);
        send_beat(CMD_WRITE, REG_RISE, 32'hFFFF_FFFF, '0);
        send_beat(CMD_WRITE, REG_FALL, 32'hFFFF_FFFF, '0);
        send_beat(CMD_WRITE, REG_MASK, 32'hFFFF_FFFF, '0);
        send_beat(CMD_SAMPLE, REG_MODE, '0, 16'hFFFF);
        send_beat(CMD_READ, REG_PENDING, '0, '0);
        send_beat(CMD_WRITE, REG_PENDING, 32'h0000_00FF, '0);
        send_beat(CMD_SAMPLE, REG_MODE, '0, 16'h0000);
        send_beat(CMD_WRITE, REG_PENDING, 32'hFFFF_FFFF, '0);
        send_beat(CMD_READ, REG_UNUSED_LO, '0, '0);
        send_beat(CMD_WRITE, REG_UNUSED_HI, 32'hFFFF_FFFF, '0);
        send_beat(CMD_UNUSED, REG_OUTPUT, 32'hFFFF_FFFF, 16'hFFFF);
        send_beat(CMD_WRITE, REG_MODE, 32'hFFFF_FFFF, '0);
        send_beat(CMD_READ, REG_MODE, '0, '0);
        drain_responses();

        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            if (n % 60 == 0)
            begin
                idle_on = ($urandom_range(0, 3) != 0);
            end
            if (n % 150 == 75)
            begin
                drain_responses();
            end
            idx  = 4'($urandom_range(0, 15));
            pick = $urandom_range(0, 9);
            case (pick)
                0:       data = '1;
                1:       data = '0;
                2:       data = {16'd0, 16'($urandom)};
                3:       data = 32'h5555_5555;
                default: data = $urandom;
            endcase
            // some beats are single-pin toggles so edges land on chosen pins
            pick = $urandom_range(0, 9);
            case (pick)
                0:       levels = '1;
                1:       levels = '0;
                2, 3, 4: levels = last_levels ^ (16'd1 << $urandom_range(0, 15));
                default: levels = 16'($urandom);
            endcase
            roll = $urandom_range(0, 99);
            if (roll < 30)
            begin
                last_levels = levels;
                send_beat(CMD_SAMPLE, idx, data, levels);
            end
            else if (roll < 65)
            begin
                send_beat(CMD_WRITE, idx, data, levels);
            end
            else if (roll < 97)
            begin
                send_beat(CMD_READ, idx, data, levels);
            end
            else
            begin
                send_beat(CMD_UNUSED, idx, data, levels);
            end
        end

        drain_responses();
        repeat (10) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hdl/gpio_pkg.sv
hdl/gpio_req_if.sv
hdl/gpio_rsp_if.sv
hdl/gpio_port_with_edge_interrupts.sv
bench/gpio_port_checker.sv
bench/gpio_port_with_edge_interrupts_tb.sv
